// ----- rtl/proximity_heat_alert_filter_assert.svh -----
// ----------------------------------------------------------------------------
// Proximity heat alert filter assertion macros
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_HEAT_ALERT_FILTER_ASSERT_SVH
`define PROXIMITY_HEAT_ALERT_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// check a property on clk_i, ignored while rst_ni is low
`define PHAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check a property on clk_i at every edge, reset included
`define PHAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define PHAF_ASSERT(lbl, prop, msg)
`define PHAF_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/phaf_pkg.sv -----
// ----------------------------------------------------------------------------
// Proximity heat alert filter package
// Shared configuration and result types, codes and fixed constants.
// ----------------------------------------------------------------------------
`default_nettype none

package phaf_pkg;

  // filter value keeps centidegrees with this many fraction bits
  localparam int unsigned FracBits = 10;
  localparam int unsigned FiltW    = 16 + FracBits;

  // filter weight is in 1/1024 units
  localparam int unsigned AlphaShift = 10;
  localparam logic [10:0] AlphaOne   = 11'd1024;

  localparam logic [7:0]         FailedStatus  = 8'd4;
  localparam logic signed [17:0] KelvinOffset  = 18'sd27315;
  localparam logic signed [17:0] TempLowCenti  = -18'sd4000;
  localparam logic signed [17:0] AmbHighCenti  = 18'sd12500;
  localparam logic signed [17:0] ObjHighCenti  = 18'sd20000;

  // configuration register indexes
  localparam logic [2:0] CFG_LASER_EN   = 3'd0;
  localparam logic [2:0] CFG_THERMAL_EN = 3'd1;
  localparam logic [2:0] CFG_RANGE_MIN  = 3'd2;
  localparam logic [2:0] CFG_RANGE_MAX  = 3'd3;
  localparam logic [2:0] CFG_LOCK_DIST  = 3'd4;
  localparam logic [2:0] CFG_HEAT_THR   = 3'd5;
  localparam logic [2:0] CFG_DELTA_THR  = 3'd6;
  localparam logic [2:0] CFG_ALPHA      = 3'd7;

  // sensor state codes
  localparam logic [1:0] LASER_GOOD      = 2'd0;
  localparam logic [1:0] LASER_OFFLINE   = 2'd1;
  localparam logic [1:0] LASER_NO_TARGET = 2'd2;

  localparam logic [1:0] THERM_VALID   = 2'd0;
  localparam logic [1:0] THERM_OFFLINE = 2'd1;
  localparam logic [1:0] THERM_ERROR   = 2'd2;

  typedef struct packed {
    logic               laser_en;
    logic               thermal_en;
    logic [15:0]        range_min;
    logic [15:0]        range_max;
    logic [15:0]        lock_dist;
    logic signed [16:0] heat_thr;
    logic signed [15:0] delta_thr;
    logic [10:0]        alpha;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         state;
    logic signed [16:0] ambient;
    logic signed [15:0] filtered;
    logic signed [15:0] delta;
    logic               heat_hit;
  } therm_res_t;

endpackage

`default_nettype wire

// ----- rtl/phaf_thermal.sv -----
// ----------------------------------------------------------------------------
// Thermal path
// Converts raw thermometer words, checks windows, runs the object filter.
// ----------------------------------------------------------------------------
`default_nettype none

module phaf_thermal (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire phaf_pkg::cfg_t      cfg_i,
  input  wire logic                update_i,
  input  wire logic                ambient_read_ok_i,
  input  wire logic [15:0]         ambient_raw_i,
  input  wire logic                object_read_ok_i,
  input  wire logic [15:0]         object_raw_i,
  output phaf_pkg::therm_res_t     res_o
);

  localparam int unsigned DiffW = phaf_pkg::FiltW + 1;
  localparam int unsigned ProdW = DiffW + 12;

  logic signed [phaf_pkg::FiltW-1:0] filt_q, filt_d, filt_upd, sample_fix;
  logic                              awaiting_q, awaiting_d;

  logic signed [17:0]       amb_c, obj_c, delta_c;
  logic                     words_ok, therm_ok;
  logic [10:0]              alpha_eff;
  logic signed [DiffW-1:0]  diff;
  logic signed [ProdW-1:0]  prod;
  logic signed [15:0]       filt_int;

  always_comb begin
    amb_c = $signed({1'b0, ambient_raw_i, 1'b0}) - phaf_pkg::KelvinOffset;
    obj_c = $signed({1'b0, object_raw_i, 1'b0}) - phaf_pkg::KelvinOffset;

    words_ok = ambient_read_ok_i && object_read_ok_i &&
               !ambient_raw_i[15] && !object_raw_i[15];
    therm_ok = cfg_i.thermal_en && words_ok &&
               (amb_c > phaf_pkg::TempLowCenti) && (amb_c < phaf_pkg::AmbHighCenti) &&
               (obj_c > phaf_pkg::TempLowCenti) && (obj_c < phaf_pkg::ObjHighCenti);

    // new sample in filter units; in-window values fit 16 bits
    sample_fix = phaf_pkg::FiltW'($signed(obj_c[15:0])) <<< phaf_pkg::FracBits;

    alpha_eff = (cfg_i.alpha > phaf_pkg::AlphaOne) ? phaf_pkg::AlphaOne : cfg_i.alpha;

    // f + floor(a * (x - f) / 1024) equals the weighted blend floored
    diff     = DiffW'(sample_fix) - DiffW'(filt_q);
    prod     = ProdW'(diff) * $signed({1'b0, alpha_eff});
    filt_upd = filt_q + prod[phaf_pkg::AlphaShift +: phaf_pkg::FiltW];

    filt_d     = filt_q;
    awaiting_d = awaiting_q;
    if (therm_ok) begin
      filt_d     = awaiting_q ? sample_fix : filt_upd;
      awaiting_d = 1'b0;
    end

    filt_int = filt_d[phaf_pkg::FiltW-1:phaf_pkg::FracBits];
    delta_c  = 18'($signed(filt_int)) - amb_c;

    res_o.filtered = filt_int;
    if (!cfg_i.thermal_en) begin
      res_o.state = phaf_pkg::THERM_OFFLINE;
    end else if (therm_ok) begin
      res_o.state = phaf_pkg::THERM_VALID;
    end else begin
      res_o.state = phaf_pkg::THERM_ERROR;
    end
    res_o.ambient  = therm_ok ? amb_c[16:0] : '0;
    res_o.delta    = therm_ok ? delta_c[15:0] : '0;
    res_o.heat_hit = therm_ok &&
                     ((17'($signed(filt_int)) >= cfg_i.heat_thr) ||
                      (delta_c >= 18'(cfg_i.delta_thr)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q     <= '0;
      awaiting_q <= 1'b1;
    end else if (update_i) begin
      filt_q     <= filt_d;
      awaiting_q <= awaiting_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/proximity_heat_alert_filter.sv -----
// ----------------------------------------------------------------------------
// Proximity heat alert filter
// Validates range and thermometer readings, filters object temperature,
// and reports the alert class with the values used.
// ----------------------------------------------------------------------------
// Pipeline: a transaction accepted into the input register moves on to the result
//   register when the output is free (input register, then result register).
// Throughput: one transaction per cycle unless the output stalls; the object
//   filter update is combinational between the input and result registers.
// Reset: configuration returns to defaults, filter clears to zero and waits
//   for its first valid sample, both pipeline stages empty.
`default_nettype none

module proximity_heat_alert_filter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [16:0]        cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         range_status_i,
  input  wire logic [15:0]        distance_mm_i,
  input  wire logic               ambient_read_ok_i,
  input  wire logic [15:0]        ambient_raw_i,
  input  wire logic               object_read_ok_i,
  input  wire logic [15:0]        object_raw_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    alert_o,
  output logic [1:0]              alert_class_o,
  output logic [1:0]              laser_state_o,
  output logic [1:0]              thermal_state_o,
  output logic [15:0]             distance_out_o,
  output logic signed [16:0]      ambient_centi_o,
  output logic signed [15:0]      object_filtered_centi_o,
  output logic signed [15:0]      delta_centi_o
);

  phaf_pkg::cfg_t cfg_q;

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  status_q;
  logic [15:0] dist_q, amb_raw_q, obj_raw_q;
  logic        amb_ok_q, obj_ok_q;

  logic        out_valid_q, out_valid_d;
  logic        out_free, advance, in_load;

  logic        range_ok, prox_hit;
  logic [1:0]  laser_state, cls;
  phaf_pkg::therm_res_t therm;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.laser_en   <= 1'b0;
      cfg_q.thermal_en <= 1'b0;
      cfg_q.range_min  <= 16'd15;
      cfg_q.range_max  <= 16'd2500;
      cfg_q.lock_dist  <= 16'd200;
      cfg_q.heat_thr   <= 17'sd3200;
      cfg_q.delta_thr  <= 16'sd200;
      cfg_q.alpha      <= 11'd358;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phaf_pkg::CFG_LASER_EN:   cfg_q.laser_en   <= cfg_wdata_i[0];
        phaf_pkg::CFG_THERMAL_EN: cfg_q.thermal_en <= cfg_wdata_i[0];
        phaf_pkg::CFG_RANGE_MIN:  cfg_q.range_min  <= cfg_wdata_i[15:0];
        phaf_pkg::CFG_RANGE_MAX:  cfg_q.range_max  <= cfg_wdata_i[15:0];
        phaf_pkg::CFG_LOCK_DIST:  cfg_q.lock_dist  <= cfg_wdata_i[15:0];
        phaf_pkg::CFG_HEAT_THR:   cfg_q.heat_thr   <= $signed(cfg_wdata_i);
        phaf_pkg::CFG_DELTA_THR:  cfg_q.delta_thr  <= $signed(cfg_wdata_i[15:0]);
        phaf_pkg::CFG_ALPHA:      cfg_q.alpha      <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    advance     = s1_valid_q && out_free;
    in_stall_o  = s1_valid_q && !out_free;
    in_load     = in_valid_i && !in_stall_o;
    s1_valid_d  = in_stall_o ? 1'b1 : in_valid_i;
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      status_q  <= range_status_i;
      dist_q    <= distance_mm_i;
      amb_ok_q  <= ambient_read_ok_i;
      amb_raw_q <= ambient_raw_i;
      obj_ok_q  <= object_read_ok_i;
      obj_raw_q <= object_raw_i;
    end
  end

  // laser path
  always_comb begin
    range_ok = cfg_q.laser_en && (status_q != phaf_pkg::FailedStatus) &&
               (dist_q >= cfg_q.range_min) && (dist_q <= cfg_q.range_max);
    if (!cfg_q.laser_en) begin
      laser_state = phaf_pkg::LASER_OFFLINE;
    end else if (range_ok) begin
      laser_state = phaf_pkg::LASER_GOOD;
    end else begin
      laser_state = phaf_pkg::LASER_NO_TARGET;
    end
    prox_hit = range_ok && (dist_q <= cfg_q.lock_dist);
  end

  phaf_thermal u_thermal (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .update_i          (advance),
    .ambient_read_ok_i (amb_ok_q),
    .ambient_raw_i     (amb_raw_q),
    .object_read_ok_i  (obj_ok_q),
    .object_raw_i      (obj_raw_q),
    .res_o             (therm)
  );

  assign cls = {therm.heat_hit, prox_hit};

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      alert_o                 <= |cls;
      alert_class_o           <= cls;
      laser_state_o           <= laser_state;
      thermal_state_o         <= therm.state;
      distance_out_o          <= range_ok ? dist_q : '0;
      ambient_centi_o         <= therm.ambient;
      object_filtered_centi_o <= therm.filtered;
      delta_centi_o           <= therm.delta;
    end
  end

  assign out_valid_o = out_valid_q;

`include "proximity_heat_alert_filter_assert.svh"

  `PHAF_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled with empty stage")
  `PHAF_ASSERT(a_stall_means_blocked, in_stall_o |-> (out_valid_o && out_stall_i), "stall without blocked output")
  `PHAF_ASSERT(a_laser_invalid_clears, (out_valid_o && laser_state_o != phaf_pkg::LASER_GOOD) |-> (distance_out_o == '0 && !alert_class_o[0]), "invalid distance leaked")
  `PHAF_ASSERT(a_thermal_invalid_clears, (out_valid_o && thermal_state_o != phaf_pkg::THERM_VALID) |-> (ambient_centi_o == '0 && delta_centi_o == '0 && !alert_class_o[1]), "invalid thermal leaked")
  `PHAF_ASSERT(a_alert_matches_class, out_valid_o |-> (alert_o == (alert_class_o != 2'd0)), "alert does not match class")

endmodule

`default_nettype wire
